// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the terrain face builder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define TZFB_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define TZFB_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tzfb_pkg.sv =====
// Types, constants and helpers of the terrain zone face builder.
`timescale 1ns / 1ps
`default_nettype none

package tzfb_pkg;

    localparam int CELLS_PER_ZONE = 8;
    localparam int MAX_MAP_SIZE   = 248;

    // Configuration register indexes.
    localparam logic [1:0] REG_MAP_SIZE     = 2'd0;
    localparam logic [1:0] REG_CELL_SPACING = 2'd1;
    localparam logic [1:0] REG_HEIGHT_SCALE = 2'd2;

    localparam logic [7:0]  MAP_SIZE_RST     = 8'd64;
    localparam logic [15:0] CELL_SPACING_RST = 16'd256;
    localparam logic [15:0] HEIGHT_SCALE_RST = 16'd256;

    localparam logic [23:0] RADIUS_SAT = 24'hFF_FFFF;

    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 136;

    localparam int SQRT_IN_W  = 64;
    localparam int SQRT_OUT_W = 32;
    localparam int DIV_NUM_W  = 45;
    localparam int DIV_DEN_W  = 31;
    localparam int DIV_Q_W    = 15;

    // Corner codes: bit 0 steps the column, bit 1 the row.
    localparam logic [1:0] CORNER_NW = 2'd0;
    localparam logic [1:0] CORNER_NE = 2'd1;
    localparam logic [1:0] CORNER_SW = 2'd2;
    localparam logic [1:0] CORNER_SE = 2'd3;

    // Normal component codes.
    localparam logic [1:0] COMP_X = 2'd0;
    localparam logic [1:0] COMP_Y = 2'd1;
    localparam logic [1:0] COMP_Z = 2'd2;

    localparam logic TRI_FIRST  = 1'b0;
    localparam logic TRI_SECOND = 1'b1;

    typedef struct packed {
        logic       load;
        logic       corner_mul;
        logic       corner_sq;
        logic       corner_root;
        logic       radius_upd;
        logic       norm_mul1;
        logic       norm_mul2;
        logic       norm_shift;
        logic       norm_sq;
        logic       norm_root;
        logic       len_latch;
        logic       div_start;
        logic       q_latch;
        logic       emit;
        logic [1:0] corner;
        logic       tri_sel;
        logic [1:0] comp;
    } tzfb_cmd_t;

    typedef struct packed {
        logic root_done;
        logic div_done;
    } tzfb_sts_t;

    function automatic logic signed [8:0] hdiff(input logic [7:0] x, input logic [7:0] y);
        hdiff = $signed({1'b0, x}) - $signed({1'b0, y});
    endfunction

    function automatic logic [7:0] hmag(input logic signed [8:0] d);
        logic [8:0] m;
        m = d[8] ? (~d + 9'd1) : d;
        hmag = m[7:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/tzfb_isqrt.sv =====
// Iterative integer square root, two radicand bits per cycle.
`timescale 1ns / 1ps
`default_nettype none

module tzfb_isqrt
    import tzfb_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [SQRT_IN_W-1:0]  radicand,
    output logic [SQRT_OUT_W-1:0] root,
    output logic                  done
);

    localparam int CNT_W = $clog2(SQRT_OUT_W + 1);

    logic [SQRT_IN_W-1:0]  rad_reg;
    logic [SQRT_OUT_W:0]   rem_reg;
    logic [SQRT_OUT_W-1:0] root_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [SQRT_OUT_W+2:0] rem_sh;
    logic [SQRT_OUT_W+2:0] trial;
    logic                  fits;

    assign rem_sh = {rem_reg, rad_reg[SQRT_IN_W-1 -: 2]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign fits   = (rem_sh >= trial);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(SQRT_OUT_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg  <= {rad_reg[SQRT_IN_W-3:0], 2'b00};
            rem_reg  <= fits ? (SQRT_OUT_W+1)'(rem_sh - trial) : rem_sh[SQRT_OUT_W:0];
            root_reg <= {root_reg[SQRT_OUT_W-2:0], fits};
        end
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

// ===== rtl/tzfb_div.sv =====
// Restoring divider, one quotient bit per cycle, for the normal scaling.
`timescale 1ns / 1ps
`default_nettype none

module tzfb_div
    import tzfb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DIV_DEN_W-1:0] den,
    output logic [DIV_Q_W-1:0]   quo,
    output logic                 done
);

    localparam int CNT_W = $clog2(DIV_Q_W + 1);

    // The caller keeps num < den * 2**DIV_Q_W, so the top part starts below den.
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_Q_W-1:0]   low_reg;
    logic [DIV_Q_W-1:0]   quo_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [DIV_DEN_W:0] sh;
    logic               fits;

    assign sh   = {rem_reg, low_reg[DIV_Q_W-1]};
    assign fits = (sh >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(DIV_Q_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= DIV_DEN_W'(num[DIV_NUM_W-1:DIV_Q_W]);
            low_reg <= num[DIV_Q_W-1:0];
            den_reg <= den;
            quo_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= fits ? DIV_DEN_W'(sh - {1'b0, den_reg}) : sh[DIV_DEN_W-1:0];
            low_reg <= {low_reg[DIV_Q_W-2:0], 1'b0};
            quo_reg <= {quo_reg[DIV_Q_W-2:0], fits};
        end
    end

    assign quo  = quo_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

// ===== rtl/tzfb_dp.sv =====
// Datapath: item capture, corner distances, face normals and output word.
`timescale 1ns / 1ps
`default_nettype none

module tzfb_dp
    import tzfb_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   s_tuser,
    input  logic [7:0]             map_size,
    input  logic [15:0]            cell_spacing,
    input  logic [15:0]            height_scale,
    input  tzfb_cmd_t              cmd,
    output tzfb_sts_t              sts,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tuser,
    output logic                   m_tlast
);

    localparam logic signed [4:0] HALF = 5'(CELLS_PER_ZONE / 2);

    // Captured item
    logic [7:0] ocol_reg, orow_reg;
    logic [2:0] ccol_reg, crow_reg;
    logic [7:0] hnw_reg, hne_reg, hsw_reg, hse_reg, hc_reg;
    logic [7:0] shade_reg, tex_reg;
    logic       texp_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            ocol_reg  <= s_tdata[7:0];
            orow_reg  <= s_tdata[15:8];
            ccol_reg  <= s_tdata[18:16];
            crow_reg  <= s_tdata[21:19];
            hnw_reg   <= s_tdata[29:22];
            hne_reg   <= s_tdata[37:30];
            hsw_reg   <= s_tdata[45:38];
            hse_reg   <= s_tdata[53:46];
            hc_reg    <= s_tdata[61:54];
            shade_reg <= s_tdata[69:62];
            tex_reg   <= s_tdata[77:70];
            texp_reg  <= s_tuser;
        end
    end

    // Shared root and divider
    logic                  root_start;
    logic [SQRT_IN_W-1:0]  root_in;
    logic [SQRT_OUT_W-1:0] root_out;
    logic                  root_done;
    logic [DIV_NUM_W-1:0]  div_num;
    logic [DIV_Q_W-1:0]    div_quo;
    logic                  div_done;

    // Corner distance
    logic [7:0]        h_sel;
    logic signed [4:0] dcol, drow;
    logic [4:0]        dcol_mag, drow_mag;
    logic [7:0]        dh_mag;
    logic [19:0]       ax_reg, az_reg;
    logic [23:0]       ay_reg;
    logic [39:0]       sx_reg, sz_reg;
    logic [47:0]       sy_reg;
    logic [23:0]       radius_reg, radius_next, r_sat;

    always_comb begin
        unique case (cmd.corner)
            CORNER_NW: h_sel = hnw_reg;
            CORNER_NE: h_sel = hne_reg;
            CORNER_SW: h_sel = hsw_reg;
            CORNER_SE: h_sel = hse_reg;
            default:   h_sel = hnw_reg;
        endcase
    end

    assign dcol = $signed({2'b00, ccol_reg}) - HALF + $signed({4'b0000, cmd.corner[0]});
    assign drow = $signed({2'b00, crow_reg}) - HALF + $signed({4'b0000, cmd.corner[1]});
    assign dcol_mag = dcol[4] ? (~dcol + 5'd1) : dcol;
    assign drow_mag = drow[4] ? (~drow + 5'd1) : drow;
    assign dh_mag   = hmag(hdiff(h_sel, hc_reg));

    always_ff @(posedge aclk) begin
        if (cmd.corner_mul) begin
            ax_reg <= 20'(dcol_mag[3:0]) * 20'(cell_spacing);
            ay_reg <= 24'(dh_mag) * 24'(height_scale);
            az_reg <= 20'(drow_mag[3:0]) * 20'(cell_spacing);
        end
        if (cmd.corner_sq) begin
            sx_reg <= 40'(ax_reg) * 40'(ax_reg);
            sy_reg <= 48'(ay_reg) * 48'(ay_reg);
            sz_reg <= 40'(az_reg) * 40'(az_reg);
        end
    end

    assign r_sat = (root_out > SQRT_OUT_W'(RADIUS_SAT)) ? RADIUS_SAT : root_out[23:0];

    always_comb begin
        radius_next = radius_reg;
        if (cmd.load && s_tdata[18:16] == 3'd0 && s_tdata[21:19] == 3'd0) begin
            radius_next = '0;
        end else if (cmd.radius_upd && r_sat > radius_reg) begin
            radius_next = r_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= '0;
        end else begin
            radius_reg <= radius_next;
        end
    end

    // Vertex indices
    logic [8:0]  col9, row9, width9;
    logic [15:0] idx_nw_reg, idx_sw_reg;

    assign col9   = 9'(ocol_reg) + 9'(ccol_reg);
    assign row9   = 9'(orow_reg) + 9'(crow_reg);
    assign width9 = 9'(map_size) + 9'd1;

    always_ff @(posedge aclk) begin
        if (cmd.corner_mul) begin
            idx_nw_reg <= 16'(18'(col9) + 18'(row9) * 18'(width9));
        end
        if (cmd.corner_sq) begin
            idx_sw_reg <= idx_nw_reg + 16'(width9);
        end
    end

    // Face normal: c = (cs*hs*a, cs*cs, cs*hs*b)
    logic signed [8:0] da, db;
    logic [31:0]       p_reg, c1_reg;
    logic [39:0]       c0_reg, c2_reg, big;
    logic              neg0_reg, neg2_reg, zero_reg;
    logic [3:0]        sh;
    logic [29:0]       ms0_reg, ms1_reg, ms2_reg, m_sel;
    logic [59:0]       sq0_reg, sq1_reg, sq2_reg;
    logic [30:0]       len_reg;
    logic [14:0]       q0_reg, q1_reg, q2_reg;

    assign da = (cmd.tri_sel == TRI_SECOND) ? hdiff(hsw_reg, hse_reg) : hdiff(hnw_reg, hne_reg);
    assign db = (cmd.tri_sel == TRI_SECOND) ? hdiff(hse_reg, hne_reg) : hdiff(hsw_reg, hnw_reg);

    always_comb begin
        big = 40'(c1_reg);
        if (c0_reg > big) big = c0_reg;
        if (c2_reg > big) big = c2_reg;
        sh = '0;
        for (int i = 0; i < 10; i++) begin
            if (big[30 + i]) sh = 4'(i + 1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.norm_mul1) begin
            p_reg  <= 32'(cell_spacing) * 32'(height_scale);
            c1_reg <= 32'(cell_spacing) * 32'(cell_spacing);
        end
        if (cmd.norm_mul2) begin
            c0_reg   <= 40'(p_reg) * 40'(hmag(da));
            c2_reg   <= 40'(p_reg) * 40'(hmag(db));
            neg0_reg <= da[8];
            neg2_reg <= db[8];
        end
        if (cmd.norm_shift) begin
            zero_reg <= (big == 40'd0);
            ms0_reg  <= 30'(c0_reg >> sh);
            ms1_reg  <= 30'(40'(c1_reg) >> sh);
            ms2_reg  <= 30'(c2_reg >> sh);
        end
        if (cmd.norm_sq) begin
            sq0_reg <= 60'(ms0_reg) * 60'(ms0_reg);
            sq1_reg <= 60'(ms1_reg) * 60'(ms1_reg);
            sq2_reg <= 60'(ms2_reg) * 60'(ms2_reg);
        end
        if (cmd.len_latch) begin
            len_reg <= root_out[30:0];
        end
        if (cmd.q_latch) begin
            unique case (cmd.comp)
                COMP_X:  q0_reg <= div_quo;
                COMP_Y:  q1_reg <= div_quo;
                COMP_Z:  q2_reg <= div_quo;
                default: q0_reg <= q0_reg;
            endcase
        end
    end

    always_comb begin
        unique case (cmd.comp)
            COMP_X:  m_sel = ms0_reg;
            COMP_Y:  m_sel = ms1_reg;
            COMP_Z:  m_sel = ms2_reg;
            default: m_sel = ms0_reg;
        endcase
    end

    // Rounded quotient: (m*16384 + len/2) / len
    assign div_num = DIV_NUM_W'({m_sel, 14'd0}) + DIV_NUM_W'(len_reg >> 1);

    assign root_start = cmd.corner_root | cmd.norm_root;
    assign root_in    = cmd.norm_root
                      ? (64'(sq0_reg) + 64'(sq1_reg) + 64'(sq2_reg))
                      : (64'(sx_reg) + 64'(sy_reg) + 64'(sz_reg));

    tzfb_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (root_start),
        .radicand (root_in),
        .root     (root_out),
        .done     (root_done)
    );

    tzfb_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (div_num),
        .den     (len_reg),
        .quo     (div_quo),
        .done    (div_done)
    );

    assign sts.root_done = root_done;
    assign sts.div_done  = div_done;

    // Output word
    logic [15:0] nx, ny, nz, v1, v2, v3;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic                   out_user_reg, out_last_reg;

    assign nx = zero_reg ? 16'd0 : (neg0_reg ? 16'd0 - 16'(q0_reg) : 16'(q0_reg));
    assign ny = zero_reg ? 16'd0 : 16'(q1_reg);
    assign nz = zero_reg ? 16'd0 : (neg2_reg ? 16'd0 - 16'(q2_reg) : 16'(q2_reg));

    // first face NW, NE, SW; second face NE, SE, SW
    assign v1 = (cmd.tri_sel == TRI_SECOND) ? idx_nw_reg + 16'd1 : idx_nw_reg;
    assign v2 = (cmd.tri_sel == TRI_SECOND) ? idx_sw_reg + 16'd1 : idx_nw_reg + 16'd1;
    assign v3 = idx_sw_reg;

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_data_reg <= {radius_reg, (texp_reg ? tex_reg : 8'd0), shade_reg,
                             nz, ny, nx, v3, v2, v1};
            out_user_reg <= texp_reg;
            out_last_reg <= cmd.tri_sel;
        end
    end

    assign m_tdata = out_data_reg;
    assign m_tuser = out_user_reg;
    assign m_tlast = out_last_reg;

endmodule

`default_nettype wire

// ===== rtl/tzfb_ctrl.sv =====
// Controller: sequences corners, normals and output words of one cell.
`timescale 1ns / 1ps
`default_nettype none

module tzfb_ctrl
    import tzfb_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    output tzfb_cmd_t cmd,
    input  tzfb_sts_t sts
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_C_MUL, ST_C_SQ, ST_C_ROOT, ST_C_WAIT,
        ST_N_MUL1, ST_N_MUL2, ST_N_SHIFT, ST_N_SQ, ST_N_ROOT, ST_N_WAIT,
        ST_N_DIV, ST_N_DWAIT, ST_EMIT
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] corner_reg, corner_next;
    logic       tri_reg, tri_next;
    logic [1:0] comp_reg, comp_next;
    logic       valid_reg, valid_next;
    logic       out_free;

    assign out_free = !valid_reg || m_tready;

    always_comb begin
        state_next  = state_reg;
        corner_next = corner_reg;
        tri_next    = tri_reg;
        comp_next   = comp_reg;
        valid_next  = valid_reg && !m_tready;
        cmd         = '0;
        cmd.corner  = corner_reg;
        cmd.tri_sel = tri_reg;
        cmd.comp    = comp_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load    = 1'b1;
                    corner_next = CORNER_NW;
                    state_next  = ST_C_MUL;
                end
            end
            ST_C_MUL: begin
                cmd.corner_mul = 1'b1;
                state_next     = ST_C_SQ;
            end
            ST_C_SQ: begin
                cmd.corner_sq = 1'b1;
                state_next    = ST_C_ROOT;
            end
            ST_C_ROOT: begin
                cmd.corner_root = 1'b1;
                state_next      = ST_C_WAIT;
            end
            ST_C_WAIT: begin
                if (sts.root_done) begin
                    cmd.radius_upd = 1'b1;
                    if (corner_reg == CORNER_SW) begin
                        tri_next   = TRI_FIRST;
                        state_next = ST_N_MUL1;
                    end else if (corner_reg == CORNER_SE) begin
                        tri_next   = TRI_SECOND;
                        state_next = ST_N_MUL1;
                    end else begin
                        corner_next = corner_reg + 2'd1;
                        state_next  = ST_C_MUL;
                    end
                end
            end
            ST_N_MUL1: begin
                cmd.norm_mul1 = 1'b1;
                state_next    = ST_N_MUL2;
            end
            ST_N_MUL2: begin
                cmd.norm_mul2 = 1'b1;
                state_next    = ST_N_SHIFT;
            end
            ST_N_SHIFT: begin
                cmd.norm_shift = 1'b1;
                state_next     = ST_N_SQ;
            end
            ST_N_SQ: begin
                cmd.norm_sq = 1'b1;
                state_next  = ST_N_ROOT;
            end
            ST_N_ROOT: begin
                cmd.norm_root = 1'b1;
                state_next    = ST_N_WAIT;
            end
            ST_N_WAIT: begin
                if (sts.root_done) begin
                    cmd.len_latch = 1'b1;
                    comp_next     = COMP_X;
                    state_next    = ST_N_DIV;
                end
            end
            ST_N_DIV: begin
                cmd.div_start = 1'b1;
                state_next    = ST_N_DWAIT;
            end
            ST_N_DWAIT: begin
                if (sts.div_done) begin
                    cmd.q_latch = 1'b1;
                    if (comp_reg == COMP_Z) begin
                        state_next = ST_EMIT;
                    end else begin
                        comp_next  = comp_reg + 2'd1;
                        state_next = ST_N_DIV;
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    cmd.emit   = 1'b1;
                    valid_next = 1'b1;
                    if (tri_reg == TRI_FIRST) begin
                        corner_next = CORNER_SE;
                        state_next  = ST_C_MUL;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            corner_reg <= CORNER_NW;
            tri_reg    <= TRI_FIRST;
            comp_reg   <= COMP_X;
            valid_reg  <= 1'b0;
        end else begin
            state_reg  <= state_next;
            corner_reg <= corner_next;
            tri_reg    <= tri_next;
            comp_reg   <= comp_next;
            valid_reg  <= valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = valid_reg;

endmodule

`default_nettype wire

// ===== rtl/terrain_zone_face_builder_unit.sv =====
// Top level of the terrain zone face builder: config registers, controller, datapath.
//
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+----------------------------------------
//  s_       | in  | s_tvalid / s_tready  | s_tdata (cell word), s_tuser
//  m_       | out | m_tvalid / m_tready  | m_tdata (face word), m_tuser, m_tlast
//  cfg_w    | in  | cfg_wvalid/cfg_wready| cfg_windex, cfg_wdata
//
// Per cell word, four corner distances and two face normals each run a
// 32-step root on the shared square-root unit, and each normal runs three
// 15-step quotients on the shared divider.
// Each cell yields two face words; the first may wait in the output register
// while the second face is computed. Reset (aresetn low, synchronous) clears
// the controller, the running radius and loads the register defaults; no
// clearing pass is needed. Config writes are always taken (cfg_wready high).
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module terrain_zone_face_builder_unit
    import tzfb_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // Cell words
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [7:0] zone_origin_col, [15:8] zone_origin_row, [18:16] cell_col,
    // [21:19] cell_row, [29:22] height_nw, [37:30] height_ne, [45:38] height_sw,
    // [53:46] height_se, [61:54] centre_height, [69:62] shade_index,
    // [77:70] texture_index, [79:78] zero
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // [0] texture_present
    input  logic                   s_tuser,
    // Face words
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [15:0] vertex_first, [31:16] vertex_second, [47:32] vertex_third,
    // [63:48] normal_x, [79:64] normal_y, [95:80] normal_z, [103:96] face_shade,
    // [111:104] face_texture, [135:112] zone_radius
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // [0] face_textured
    output logic                   m_tuser,
    // last_face
    output logic                   m_tlast,
    // Config writes
    input  logic                   cfg_wvalid,
    output logic                   cfg_wready,
    input  logic [1:0]             cfg_windex,
    input  logic [15:0]            cfg_wdata
);

    logic [7:0]  map_size_reg;
    logic [15:0] cell_spacing_reg;
    logic [15:0] height_scale_reg;
    logic [7:0]  map_size_wr;

    // map_size saturates at the largest supported map
    assign map_size_wr = (int'(cfg_wdata[7:0]) > MAX_MAP_SIZE) ? 8'(MAX_MAP_SIZE)
                                                                : cfg_wdata[7:0];
    assign cfg_wready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_size_reg     <= MAP_SIZE_RST;
            cell_spacing_reg <= CELL_SPACING_RST;
            height_scale_reg <= HEIGHT_SCALE_RST;
        end else if (cfg_wvalid && cfg_wready) begin
            unique case (cfg_windex)
                REG_MAP_SIZE:     map_size_reg     <= map_size_wr;
                REG_CELL_SPACING: cell_spacing_reg <= cfg_wdata;
                REG_HEIGHT_SCALE: height_scale_reg <= cfg_wdata;
                default:          ; // unknown index ignored
            endcase
        end
    end

    tzfb_cmd_t cmd;
    tzfb_sts_t sts;

    tzfb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    tzfb_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .map_size     (map_size_reg),
        .cell_spacing (cell_spacing_reg),
        .height_scale (height_scale_reg),
        .cmd          (cmd),
        .sts          (sts),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast)
    );

    // A cell word keeps the block busy until its second face is in the output register.
    `TZFB_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready, "block took a new cell right after accepting one")
    // A pending first face means the second is still in work.
    `TZFB_ASSERT_IMPL(a_first_face_busy, aclk, aresetn, m_tvalid && !m_tlast, !s_tready, "ready for a cell while the first face is pending")
    // Normal x component stays within unit range.
    `TZFB_ASSERT_IMPL(a_normal_x_range, aclk, aresetn, m_tvalid, ($signed(m_tdata[63:48]) >= -16'sd16384) && ($signed(m_tdata[63:48]) <= 16'sd16384), "normal_x outside unit range")

endmodule

`default_nettype wire

// ===== test/terrain_zone_face_builder_unit_checker.sv =====
// Checker for the terrain zone face builder: predicts face words and compares them.
`timescale 1ns / 1ps

module terrain_zone_face_builder_unit_checker
    import tzfb_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   s_tuser,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   m_tuser,
    input  logic                   m_tlast,
    input  logic                   cfg_wvalid,
    input  logic                   cfg_wready,
    input  logic [1:0]             cfg_windex,
    input  logic [15:0]            cfg_wdata,
    output int                     err_count,
    output int                     faces_pending
);

    typedef struct {
        logic [15:0] v0, v1, v2;
        logic [15:0] nx, ny, nz;
        logic [7:0]  shade, tex;
        logic        textured;
        logic [23:0] radius;
        logic        last;
    } face_t;

    face_t       face_q[$];
    logic [7:0]  map_sz;
    logic [15:0] spacing, hscale;
    logic [23:0] radius_max;

    function automatic logic [63:0] root64(input logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] absv(input longint x);
        return x < 0 ? -x : x;
    endfunction

    // Corner offsets in grid steps and height difference to the zone center.
    function automatic void fold_corner(input longint dcol, input longint drow,
                                        input longint dh);
        logic [63:0] ax, ay, az, r;
        ax = absv(dcol) * spacing;
        ay = absv(dh) * hscale;
        az = absv(drow) * spacing;
        r  = root64(ax * ax + ay * ay + az * az);
        if (r > 64'hFF_FFFF) r = 64'hFF_FFFF;
        if (r > radius_max) radius_max = r[23:0];
    endfunction

    // Edges u, v from the first vertex; returns {z, y, x} in Q1.14.
    function automatic logic [47:0] unit_normal(input longint uc, input longint ur,
                                                input longint vc, input longint vr,
                                                input longint dh1, input longint dh2);
        longint      cs, hs, u0, u1, u2, w0, w1, w2;
        longint      c[3];
        logic [63:0] m[3];
        logic [63:0] big, sum, len, q;
        logic [15:0] n[3];
        int          sh;
        cs = spacing;
        hs = hscale;
        u0 = uc * cs;  u1 = dh1 * hs;  u2 = -ur * cs;
        w0 = vc * cs;  w1 = dh2 * hs;  w2 = -vr * cs;
        c[0] = u1 * w2 - u2 * w1;
        c[1] = u2 * w0 - u0 * w2;
        c[2] = u0 * w1 - u1 * w0;
        big = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = absv(c[i]);
            if (m[i] > big) big = m[i];
        end
        if (big == 0) return '0;
        sh = 0;
        while ((big >> sh) >= 64'd1 << 30) sh++;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = m[i] >> sh;
            sum  = sum + m[i] * m[i];
        end
        len = root64(sum);
        for (int i = 0; i < 3; i++) begin
            q    = len != 0 ? (m[i] * 16384 + len / 2) / len : 0;
            n[i] = c[i] < 0 ? -q[15:0] : q[15:0];
        end
        return {n[2], n[1], n[0]};
    endfunction

    function automatic void predict_cell(input logic [IN_TDATA_W-1:0] d, input logic tex);
        int          oc, orow, cc, cr, wd;
        longint      hnw, hne, hsw, hse, hc, dc, dr;
        logic [15:0] inw, ine, isw, ise;
        logic [47:0] n;
        face_t       f;
        oc = d[7:0];    orow = d[15:8];
        cc = d[18:16];  cr = d[21:19];
        hnw = d[29:22]; hne = d[37:30]; hsw = d[45:38]; hse = d[53:46];
        hc  = d[61:54];
        dc = cc - CELLS_PER_ZONE / 2;
        dr = cr - CELLS_PER_ZONE / 2;
        wd = map_sz + 1;
        inw = 16'((oc + cc) + (orow + cr) * wd);
        ine = inw + 16'd1;
        isw = 16'((oc + cc) + (orow + cr + 1) * wd);
        ise = isw + 16'd1;
        if (cc == 0 && cr == 0) radius_max = '0;   // zone start
        f.shade    = d[69:62];
        f.tex      = tex ? d[77:70] : 8'd0;
        f.textured = tex;

        fold_corner(dc, dr, hnw - hc);
        fold_corner(dc + 1, dr, hne - hc);
        fold_corner(dc, dr + 1, hsw - hc);
        n = unit_normal(1, 0, 0, 1, hne - hnw, hsw - hnw);
        f.v0 = inw; f.v1 = ine; f.v2 = isw;
        {f.nz, f.ny, f.nx} = n;
        f.radius = radius_max;
        f.last   = TRI_FIRST;
        face_q.push_back(f);

        fold_corner(dc + 1, dr + 1, hse - hc);
        n = unit_normal(0, 1, -1, 1, hse - hne, hsw - hne);
        f.v0 = ine; f.v1 = ise; f.v2 = isw;
        {f.nz, f.ny, f.nx} = n;
        f.radius = radius_max;
        f.last   = TRI_SECOND;
        face_q.push_back(f);
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
        err_count++;
    endtask

    task automatic check_face();
        face_t f;
        if (face_q.size() == 0) begin
            report_mismatch("face word with nothing expected", 1, 0);
            return;
        end
        f = face_q.pop_front();
        if (m_tdata[15:0]    !== f.v0)       report_mismatch("vertex_first", m_tdata[15:0], f.v0);
        if (m_tdata[31:16]   !== f.v1)       report_mismatch("vertex_second", m_tdata[31:16], f.v1);
        if (m_tdata[47:32]   !== f.v2)       report_mismatch("vertex_third", m_tdata[47:32], f.v2);
        if (m_tdata[63:48]   !== f.nx)
            report_mismatch("normal_x", $signed(m_tdata[63:48]), $signed(f.nx));
        if (m_tdata[79:64]   !== f.ny)
            report_mismatch("normal_y", $signed(m_tdata[79:64]), $signed(f.ny));
        if (m_tdata[95:80]   !== f.nz)
            report_mismatch("normal_z", $signed(m_tdata[95:80]), $signed(f.nz));
        if (m_tdata[103:96]  !== f.shade)    report_mismatch("face_shade", m_tdata[103:96], f.shade);
        if (m_tdata[111:104] !== f.tex)      report_mismatch("face_texture", m_tdata[111:104], f.tex);
        if (m_tdata[135:112] !== f.radius)
            report_mismatch("zone_radius", m_tdata[135:112], f.radius);
        if (m_tuser !== f.textured)          report_mismatch("face_textured", m_tuser, f.textured);
        if (m_tlast !== f.last)              report_mismatch("last_face", m_tlast, f.last);
    endtask

    initial begin
        err_count     = 0;
        faces_pending = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            map_sz     = MAP_SIZE_RST;
            spacing    = CELL_SPACING_RST;
            hscale     = HEIGHT_SCALE_RST;
            radius_max = '0;
            face_q.delete();
        end else begin
            if (cfg_wvalid && cfg_wready) begin
                case (cfg_windex)
                    REG_MAP_SIZE:
                        map_sz = cfg_wdata[7:0] > MAX_MAP_SIZE ? 8'(MAX_MAP_SIZE) : cfg_wdata[7:0];
                    REG_CELL_SPACING: spacing = cfg_wdata;
                    REG_HEIGHT_SCALE: hscale  = cfg_wdata;
                    default: ;   // unknown index is dropped
                endcase
            end
            if (m_tvalid && m_tready) check_face();
            if (s_tvalid && s_tready) predict_cell(s_tdata, s_tuser);
        end
        faces_pending = face_q.size();
    end

endmodule

// ===== test/terrain_zone_face_builder_unit_tb.sv =====
// Testbench top for the terrain zone face builder: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module terrain_zone_face_builder_unit_tb;
    import tzfb_pkg::*;

    localparam int STALL_LIMIT = 20000;   // cycles with no word moving on any channel
    localparam int HOLD_CYCLES = 3000;    // long receiver hold-off

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid, s_tready, s_tuser;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid, m_tready, m_tuser, m_tlast;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_wvalid, cfg_wready;
    logic [1:0]             cfg_windex;
    logic [15:0]            cfg_wdata;

    int err_count, faces_pending;
    int send_idle_pct, recv_idle_pct;   // owned by the stimulus process
    bit hold_go;                        // request one long receiver hold-off
    int zone_cell;                      // walk position inside the current zone
    logic [7:0] zone_col, zone_row, zone_hc;

    terrain_zone_face_builder_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_wvalid(cfg_wvalid), .cfg_wready(cfg_wready),
        .cfg_windex(cfg_windex), .cfg_wdata(cfg_wdata)
    );

    terrain_zone_face_builder_unit_checker face_check (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_wvalid(cfg_wvalid), .cfg_wready(cfg_wready),
        .cfg_windex(cfg_windex), .cfg_wdata(cfg_wdata),
        .err_count(err_count), .faces_pending(faces_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Cell word layout, low bits first: origin col/row, cell col/row, four corner
    // heights, center height, shade, texture.
    function automatic logic [IN_TDATA_W-1:0] cell_word(
        input logic [7:0] oc, input logic [7:0] orow, input logic [2:0] cc,
        input logic [2:0] cr, input logic [7:0] hnw, input logic [7:0] hne,
        input logic [7:0] hsw, input logic [7:0] hse, input logic [7:0] hc,
        input logic [7:0] shade, input logic [7:0] texi);
        return {2'b00, texi, shade, hc, hse, hsw, hne, hnw, cr, cc, orow, oc};
    endfunction

    // Heights lean to the extremes now and then.
    function automatic logic [7:0] rand_height();
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic push_cell(input logic [IN_TDATA_W-1:0] d, input logic tex);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= tex;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_wvalid <= 1'b1;
        cfg_windex <= idx;
        cfg_wdata  <= val;
        do @(posedge aclk); while (!cfg_wready);
        cfg_wvalid <= 1'b0;
        @(posedge aclk);
    endtask

    // Registers only move once every face word is out; the first edge lets the
    // checker take in a cell accepted at the last edge.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (faces_pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Mostly walk a zone from cell (0,0) onward; sometimes a stray cell.
    task automatic random_cell();
        logic [2:0] cc, cr;
        if (zone_cell >= 64 || $urandom_range(0, 39) == 0) begin
            zone_cell = 0;
            zone_col  = $urandom_range(0, 7) == 0 ? 8'($urandom_range(241, 255))
                                                 : 8'($urandom_range(0, 240));
            zone_row  = $urandom_range(0, 7) == 0 ? 8'($urandom_range(241, 255))
                                                 : 8'($urandom_range(0, 240));
            zone_hc   = rand_height();
        end
        if ($urandom_range(0, 9) < 8) begin
            cc = zone_cell[2:0];
            cr = zone_cell[5:3];
            zone_cell++;
        end else begin
            cc = 3'($urandom_range(0, 7));
            cr = 3'($urandom_range(0, 7));
        end
        push_cell(cell_word(zone_col, zone_row, cc, cr, rand_height(), rand_height(),
                            rand_height(), rand_height(), zone_hc,
                            8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))),
                  1'($urandom_range(0, 1)));
    endtask

    task automatic random_config();
        case ($urandom_range(0, 3))
            0:       write_reg(REG_MAP_SIZE, 16'(8 * $urandom_range(8, 31)));
            1:       write_reg(REG_MAP_SIZE, 16'($urandom_range(0, 65535)));
            default: write_reg(REG_MAP_SIZE, 16'd248);
        endcase
        case ($urandom_range(0, 3))
            0:       write_reg(REG_CELL_SPACING, 16'd65535);
            1:       write_reg(REG_CELL_SPACING, 16'd1);
            default: write_reg(REG_CELL_SPACING, 16'($urandom_range(1, 65535)));
        endcase
        case ($urandom_range(0, 3))
            0:       write_reg(REG_HEIGHT_SCALE, 16'd0);
            1:       write_reg(REG_HEIGHT_SCALE, 16'd65535);
            default: write_reg(REG_HEIGHT_SCALE, 16'($urandom_range(0, 65535)));
        endcase
    endtask

    // Stimulus
    initial begin
        logic [1:0] bad_idx;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = 1'b0;
        cfg_wvalid = 1'b0;
        cfg_windex = REG_MAP_SIZE;
        cfg_wdata  = '0;
        hold_go    = 1'b0;
        zone_cell  = 64;
        send_idle_pct = 23;
        recv_idle_pct = 88;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed, reset register values: zone start, flat/steep faces, corners.
        push_cell(cell_word(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0);
        push_cell(cell_word(0, 0, 7, 7, 255, 255, 255, 255, 0, 255, 255), 1'b1);
        push_cell(cell_word(0, 0, 3, 4, 255, 0, 0, 255, 128, 8'h55, 8'hAA), 1'b1);
        push_cell(cell_word(0, 0, 4, 3, 0, 255, 255, 0, 255, 8'hAA, 8'h55), 1'b0);
        push_cell(cell_word(240, 240, 7, 0, 10, 200, 30, 90, 17, 1, 2), 1'b1);
        push_cell(cell_word(255, 255, 7, 7, 255, 0, 255, 0, 0, 128, 128), 1'b1);
        push_cell(cell_word(8, 16, 0, 7, 1, 2, 3, 4, 5, 6, 7), 1'b0);

        // Largest map, widest spacing and scale; an over-range map size saturates.
        drain();
        write_reg(REG_MAP_SIZE, 16'hFFFF);
        write_reg(REG_CELL_SPACING, 16'd65535);
        write_reg(REG_HEIGHT_SCALE, 16'd65535);
        push_cell(cell_word(0, 0, 0, 0, 0, 255, 255, 0, 255, 9, 9), 1'b1);
        push_cell(cell_word(240, 240, 7, 7, 255, 255, 0, 0, 0, 10, 10), 1'b1);
        push_cell(cell_word(200, 100, 0, 7, 0, 0, 0, 0, 255, 11, 11), 1'b0);
        push_cell(cell_word(255, 255, 7, 7, 255, 0, 0, 255, 128, 12, 12), 1'b1);

        // Zero spacing gives a zero normal; zero scale, map size 64; stray index.
        drain();
        write_reg(REG_MAP_SIZE, 16'd64);
        write_reg(REG_CELL_SPACING, 16'd0);
        write_reg(REG_HEIGHT_SCALE, 16'd0);
        bad_idx = 2'd3;
        write_reg(bad_idx, 16'd1234);
        push_cell(cell_word(0, 0, 0, 0, 200, 10, 30, 40, 50, 1, 2), 1'b1);
        push_cell(cell_word(64, 64, 2, 5, 255, 0, 255, 0, 0, 3, 4), 1'b0);
        drain();
        write_reg(REG_CELL_SPACING, 16'd1);
        push_cell(cell_word(0, 0, 0, 0, 255, 0, 0, 255, 0, 5, 6), 1'b1);
        push_cell(cell_word(0, 0, 1, 0, 0, 0, 0, 0, 0, 7, 8), 1'b0);

        // Random part: six settings, idling pattern changes across the run.
        for (int ph = 0; ph < 6; ph++) begin
            drain();
            random_config();
            zone_cell = 64;
            send_idle_pct = ph < 2 ? 23 : (ph < 4 ? 88 : 0);
            recv_idle_pct = ph < 2 ? 88 : (ph < 4 ? 23 : 0);
            for (int k = 0; k < 72; k++) begin
                if (ph == 1 && k == 20) hold_go = 1'b1;
                random_cell();
            end
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (faces_pending != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off so the block backs up.
    initial begin
        bit hold_taken;
        hold_taken = 1'b0;
        m_tready   = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_go && !hold_taken) begin
                hold_taken = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_tready <= $urandom_range(0, 99) >= recv_idle_pct;
        end
    end

    // Watchdog: too long with no word moving on any channel.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (cfg_wvalid && cfg_wready) || !aresetn)
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
